// File: rtl/dlmc_pkg.sv
package dlmc_pkg;

    localparam int TIMER_WIDTH_DEFAULT = 16;

    localparam int DEB_W   = 10;
    localparam int BLINK_W = 16;
    localparam int LED_W   = 8;
    localparam int FADE_W  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [DEB_W-1:0]   DEB_CNT_MAX      = '1;
    localparam logic [DEB_W-1:0]   DEBOUNCE_RESET   = DEB_W'(25);
    localparam logic [BLINK_W-1:0] BLINK_RESET      = BLINK_W'(400);
    localparam logic [FADE_W-1:0]  FADE_PEAK_RESET  = FADE_W'(180);
    localparam logic [FADE_W-1:0]  FADE_PERIOD_RESET = FADE_W'(20);
    localparam logic [LED_W-1:0]   LED_FULL = '1;
    localparam logic [LED_W-1:0]   LED_DARK = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE    = 2'd0,
        CFG_BLINK       = 2'd1,
        CFG_FADE_PEAK   = 2'd2,
        CFG_FADE_PERIOD = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MODE_OFF   = 2'd0,
        MODE_BLINK = 2'd1,
        MODE_ON    = 2'd2,
        MODE_FADE  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_PRESS   = 2'd1,
        EV_RELEASE = 2'd2
    } btn_ev_t;

    typedef struct packed {
        logic [DEB_W-1:0] cnt;
        logic             held;
        btn_ev_t          ev;
    } deb_t;

    function automatic deb_t debounce(
        input logic             lvl,
        input logic             prev,
        input logic [DEB_W-1:0] cnt,
        input logic             held,
        input logic [DEB_W-1:0] ticks
    );
        deb_t r;
        r.held = held;
        r.ev   = EV_NONE;
        if (lvl != prev)
        begin
            r.cnt = '0;
        end
        else if (cnt != DEB_CNT_MAX)
        begin
            r.cnt = cnt + DEB_W'(1);
        end
        else
        begin
            r.cnt = cnt;
        end
        if (r.cnt > ticks)
        begin
            if (!lvl && !held)
            begin
                r.held = 1'b1;
                r.ev   = EV_PRESS;
            end
            else if (lvl)
            begin
                r.held = 1'b0;
                r.ev   = EV_RELEASE;
            end
        end
        return r;
    endfunction

endpackage

// File: rtl/debounced_led_mode_controller_top.sv
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+---------------------------------------------
// in       | sink      | in_valid/in_stall  | mode_button_level, reset_button_level
// out      | source    | out_valid/out_stall| led_a_level, led_b_level, indicator_on,
//          |           |                    | current_mode, mode_entered
// cfg      | sink      | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Each tick transaction is captured in an input register and processed into the result
// register, and one transaction is taken every cycle unless the output stalls; the single
// pass through the debounce and mode logic sets that rate.
// Reset is asynchronous and active low and restores every control and state register.
// A stall on the output holds the result register and the input register, and the
// input side stalls only while both are full.
module debounced_led_mode_controller_top
    import dlmc_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  mode_button_level,
    input  logic                  reset_button_level,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [LED_W-1:0]      led_a_level,
    output logic [LED_W-1:0]      led_b_level,
    output logic                  indicator_on,
    output logic [1:0]            current_mode,
    output logic                  mode_entered,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CMP_W = (TIMER_WIDTH > BLINK_W) ? TIMER_WIDTH : BLINK_W;
    localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = '1;

    logic [DEB_W-1:0]       debounce_ticks_reg;
    logic [BLINK_W-1:0]     blink_interval_reg;
    logic [FADE_W-1:0]      fade_peak_reg;
    logic [FADE_W-1:0]      fade_period_reg;

    logic                   s1_valid_reg;
    logic                   s1_mode_lvl_reg;
    logic                   s1_reset_lvl_reg;
    logic                   out_valid_reg;
    logic                   advance;

    mode_t                  mode_reg, mode_next;
    logic                   mode_prev_reg;
    logic [DEB_W-1:0]       mode_cnt_reg, mode_cnt_next;
    logic                   mode_held_reg, mode_held_next;
    logic                   reset_prev_reg;
    logic [DEB_W-1:0]       reset_cnt_reg, reset_cnt_next;
    logic                   reset_held_reg, reset_held_next;
    logic [TIMER_WIDTH-1:0] blink_count_reg, blink_count_next;
    logic                   blink_phase_reg, blink_phase_next;
    logic [FADE_W-1:0]      fade_level_reg, fade_level_next;
    logic                   fade_rising_reg, fade_rising_next;
    logic [FADE_W-1:0]      fade_count_reg, fade_count_next;
    logic [LED_W-1:0]       led_a_reg, led_a_next;
    logic [LED_W-1:0]       led_b_reg, led_b_next;
    logic                   indicator_reg, indicator_next;
    logic                   entered_reg, entered_next;

    deb_t                   mode_deb;
    deb_t                   reset_deb;
    logic signed [FADE_W+1:0] fade_step;
    logic [FADE_W:0]        fade_cnt_inc;

    assign advance   = s1_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall  = s1_valid_reg && out_valid_reg && out_stall;
    assign cfg_ready = 1'b1;

    assign out_valid    = out_valid_reg;
    assign led_a_level  = led_a_reg;
    assign led_b_level  = led_b_reg;
    assign indicator_on = indicator_reg;
    assign current_mode = mode_reg;
    assign mode_entered = entered_reg;

    always_comb
    begin
        mode_deb  = debounce(s1_mode_lvl_reg, mode_prev_reg, mode_cnt_reg,
                             mode_held_reg, debounce_ticks_reg);
        reset_deb = debounce(s1_reset_lvl_reg, reset_prev_reg, reset_cnt_reg,
                             reset_held_reg, debounce_ticks_reg);

        mode_next        = mode_reg;
        mode_cnt_next    = mode_deb.cnt;
        mode_held_next   = mode_deb.held;
        reset_cnt_next   = reset_deb.cnt;
        reset_held_next  = reset_deb.held;
        blink_phase_next = blink_phase_reg;
        fade_level_next  = fade_level_reg;
        fade_rising_next = fade_rising_reg;
        fade_count_next  = fade_count_reg;
        led_a_next       = led_a_reg;
        led_b_next       = led_b_reg;
        indicator_next   = indicator_reg;
        entered_next     = 1'b0;
        fade_step        = '0;
        fade_cnt_inc     = '0;

        if (blink_count_reg != TIMER_MAX)
        begin
            blink_count_next = blink_count_reg + TIMER_WIDTH'(1);
        end
        else
        begin
            blink_count_next = blink_count_reg;
        end

        if (mode_deb.ev == EV_PRESS)
        begin
            indicator_next = 1'b1;
            entered_next   = 1'b1;
            mode_next      = mode_t'(mode_reg + 2'd1);
            unique case (mode_next)
                MODE_OFF, MODE_BLINK:
                begin
                    led_a_next     = LED_DARK;
                    led_b_next     = LED_DARK;
                    indicator_next = 1'b0;
                    if (mode_next == MODE_BLINK)
                    begin
                        blink_count_next = '0;
                    end
                end
                MODE_ON:
                begin
                    led_a_next     = LED_FULL;
                    led_b_next     = LED_FULL;
                    indicator_next = 1'b1;
                end
                MODE_FADE:
                begin
                    fade_level_next  = '0;
                    fade_rising_next = 1'b1;
                    fade_count_next  = '0;
                end
                default:
                begin
                    mode_next = MODE_OFF;
                end
            endcase
        end
        else if (mode_deb.ev == EV_RELEASE)
        begin
            indicator_next = 1'b0;
        end

        if (reset_deb.ev == EV_PRESS)
        begin
            mode_next      = MODE_OFF;
            led_a_next     = LED_DARK;
            led_b_next     = LED_DARK;
            indicator_next = 1'b0;
            entered_next   = 1'b1;
        end
        else if (reset_deb.ev == EV_RELEASE)
        begin
            indicator_next = 1'b0;
        end

        if (mode_next == MODE_BLINK)
        begin
            if (CMP_W'(blink_count_next) >= CMP_W'(blink_interval_reg))
            begin
                blink_count_next = '0;
                blink_phase_next = !blink_phase_reg;
                led_a_next       = blink_phase_next ? LED_FULL : LED_DARK;
                led_b_next       = blink_phase_next ? LED_DARK : LED_FULL;
                indicator_next   = 1'b0;
            end
        end
        else if (mode_next == MODE_FADE)
        begin
            if (fade_count_next == '0)
            begin
                fade_step = $signed({2'b00, fade_level_next})
                          + (fade_rising_next ? 10'sd1 : -10'sd1);
                if (fade_step >= $signed({2'b00, fade_peak_reg}))
                begin
                    fade_step        = $signed({2'b00, fade_peak_reg});
                    fade_rising_next = 1'b0;
                end
                if (fade_step <= 10'sd0)
                begin
                    fade_step        = '0;
                    fade_rising_next = 1'b1;
                end
                fade_level_next = fade_step[FADE_W-1:0];
                led_a_next      = fade_level_next;
                led_b_next      = fade_level_next;
                indicator_next  = 1'b0;
            end
            fade_cnt_inc = {1'b0, fade_count_next} + (FADE_W+1)'(1);
            if (fade_cnt_inc >= {1'b0, fade_period_reg})
            begin
                fade_count_next = '0;
            end
            else
            begin
                fade_count_next = fade_cnt_inc[FADE_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ticks_reg <= DEBOUNCE_RESET;
            blink_interval_reg <= BLINK_RESET;
            fade_peak_reg      <= FADE_PEAK_RESET;
            fade_period_reg    <= FADE_PERIOD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_DEBOUNCE:    debounce_ticks_reg <= cfg_data[DEB_W-1:0];
                CFG_BLINK:       blink_interval_reg <= cfg_data[BLINK_W-1:0];
                CFG_FADE_PEAK:   fade_peak_reg      <= cfg_data[FADE_W-1:0];
                CFG_FADE_PERIOD: fade_period_reg    <= cfg_data[FADE_W-1:0];
                default:         debounce_ticks_reg <= debounce_ticks_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_stall ? 1'b1 : in_valid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            s1_mode_lvl_reg  <= mode_button_level;
            s1_reset_lvl_reg <= reset_button_level;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_OFF;
            mode_prev_reg   <= 1'b1;
            mode_cnt_reg    <= '0;
            mode_held_reg   <= 1'b0;
            reset_prev_reg  <= 1'b1;
            reset_cnt_reg   <= '0;
            reset_held_reg  <= 1'b0;
            blink_count_reg <= '0;
            blink_phase_reg <= 1'b0;
            fade_level_reg  <= '0;
            fade_rising_reg <= 1'b1;
            fade_count_reg  <= '0;
            led_a_reg       <= '0;
            led_b_reg       <= '0;
            indicator_reg   <= 1'b0;
            entered_reg     <= 1'b0;
        end
        else if (advance)
        begin
            mode_reg        <= mode_next;
            mode_prev_reg   <= s1_mode_lvl_reg;
            mode_cnt_reg    <= mode_cnt_next;
            mode_held_reg   <= mode_held_next;
            reset_prev_reg  <= s1_reset_lvl_reg;
            reset_cnt_reg   <= reset_cnt_next;
            reset_held_reg  <= reset_held_next;
            blink_count_reg <= blink_count_next;
            blink_phase_reg <= blink_phase_next;
            fade_level_reg  <= fade_level_next;
            fade_rising_reg <= fade_rising_next;
            fade_count_reg  <= fade_count_next;
            led_a_reg       <= led_a_next;
            led_b_reg       <= led_b_next;
            indicator_reg   <= indicator_next;
            entered_reg     <= entered_next;
        end
    end

    // The input side only stalls while a transaction waits in the input register.
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with an empty input register");

    // Both LEDs are fully on whenever the both-on mode is shown.
    a_mode_on_leds: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_ON) |-> (led_a_reg == LED_FULL && led_b_reg == LED_FULL))
        else $error("both-on mode with LEDs not fully on");

    // Both LEDs are dark whenever the off mode is shown.
    a_mode_off_leds: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_OFF) |-> (led_a_reg == LED_DARK && led_b_reg == LED_DARK))
        else $error("off mode with an LED lit");

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb
    import dlmc_pkg::*;
();

    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          SETTLE_CYCLES  = 4;
    localparam int unsigned BLINK_SAT      = (1 << TIMER_WIDTH_DEFAULT) - 1;
    localparam int          MODE_IDX       = 0;
    localparam int          RESET_IDX      = 1;

    typedef struct {
        logic [LED_W-1:0] led_a;
        logic [LED_W-1:0] led_b;
        logic             ind;
        mode_t            mode;
        logic             entered;
    } led_frame_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  mode_button_level = 1'b1;
    logic                  reset_button_level = 1'b1;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [LED_W-1:0]      led_a_level;
    logic [LED_W-1:0]      led_b_level;
    logic                  indicator_on;
    logic [1:0]            current_mode;
    logic                  mode_entered;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    led_frame_t led_frames_due[$];
    int         mismatches = 0;
    int         idle_cycles = 0;
    bit         quiet = 1'b0;

    logic [DEB_W-1:0]   deb_ticks;
    logic [BLINK_W-1:0] blink_ivl;
    logic [FADE_W-1:0]  fade_peak;
    logic [FADE_W-1:0]  fade_per;

    mode_t            cur_mode;
    logic             btn_prev[2];
    logic [DEB_W-1:0] btn_cnt[2];
    logic             btn_held[2];
    int unsigned      blink_cnt;
    logic             blink_phase;
    logic [FADE_W-1:0] fade_lvl;
    logic             fade_up;
    int               fade_cnt;
    logic [LED_W-1:0] led_a_reg;
    logic [LED_W-1:0] led_b_reg;
    logic             ind_reg;

    debounced_led_mode_controller_top u_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .mode_button_level  (mode_button_level),
        .reset_button_level (reset_button_level),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .led_a_level        (led_a_level),
        .led_b_level        (led_b_level),
        .indicator_on       (indicator_on),
        .current_mode       (current_mode),
        .mode_entered       (mode_entered),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic void flag_error(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
    endfunction

    function automatic void reset_led_model();
        deb_ticks   = DEBOUNCE_RESET;
        blink_ivl   = BLINK_RESET;
        fade_peak   = FADE_PEAK_RESET;
        fade_per    = FADE_PERIOD_RESET;
        cur_mode    = MODE_OFF;
        for (int b = 0; b < 2; b++)
        begin
            btn_prev[b] = 1'b1;
            btn_cnt[b]  = '0;
            btn_held[b] = 1'b0;
        end
        blink_cnt   = 0;
        blink_phase = 1'b0;
        fade_lvl    = '0;
        fade_up     = 1'b1;
        fade_cnt    = 0;
        led_a_reg   = LED_DARK;
        led_b_reg   = LED_DARK;
        ind_reg     = 1'b0;
    endfunction

    function automatic btn_ev_t filter_button(input int b, input logic lvl);
        btn_ev_t ev;
        ev = EV_NONE;
        if (lvl != btn_prev[b])
            btn_cnt[b] = '0;
        else if (btn_cnt[b] != DEB_CNT_MAX)
            btn_cnt[b] = btn_cnt[b] + 1'b1;
        if (btn_cnt[b] > deb_ticks)
        begin
            if (!lvl && !btn_held[b])
            begin
                btn_held[b] = 1'b1;
                ev = EV_PRESS;
            end
            else if (lvl)
            begin
                btn_held[b] = 1'b0;
                ev = EV_RELEASE;
            end
        end
        btn_prev[b] = lvl;
        return ev;
    endfunction

    function automatic led_frame_t step_led_controller(input logic mlev, input logic rlev);
        led_frame_t f;
        btn_ev_t    ev;
        int         next_lvl;
        f.entered = 1'b0;
        if (blink_cnt < BLINK_SAT)
            blink_cnt++;

        ev = filter_button(MODE_IDX, mlev);
        if (ev == EV_PRESS)
        begin
            ind_reg  = 1'b1;
            cur_mode = mode_t'(cur_mode + 2'd1);
            case (cur_mode)
                MODE_OFF, MODE_BLINK:
                begin
                    led_a_reg = LED_DARK;
                    led_b_reg = LED_DARK;
                    ind_reg   = 1'b0;
                    if (cur_mode == MODE_BLINK)
                        blink_cnt = 0;
                end
                MODE_ON:
                begin
                    led_a_reg = LED_FULL;
                    led_b_reg = LED_FULL;
                    ind_reg   = 1'b1;
                end
                default:
                begin
                    fade_lvl = '0;
                    fade_up  = 1'b1;
                    fade_cnt = 0;
                end
            endcase
            f.entered = 1'b1;
        end
        else if (ev == EV_RELEASE)
            ind_reg = 1'b0;

        ev = filter_button(RESET_IDX, rlev);
        if (ev == EV_PRESS)
        begin
            cur_mode  = MODE_OFF;
            led_a_reg = LED_DARK;
            led_b_reg = LED_DARK;
            ind_reg   = 1'b0;
            f.entered = 1'b1;
        end
        else if (ev == EV_RELEASE)
            ind_reg = 1'b0;

        if (cur_mode == MODE_BLINK)
        begin
            if (blink_cnt >= blink_ivl)
            begin
                blink_cnt   = 0;
                blink_phase = ~blink_phase;
                led_a_reg   = blink_phase ? LED_FULL : LED_DARK;
                led_b_reg   = blink_phase ? LED_DARK : LED_FULL;
                ind_reg     = 1'b0;
            end
        end
        else if (cur_mode == MODE_FADE)
        begin
            if (fade_cnt == 0)
            begin
                next_lvl = int'(fade_lvl) + (fade_up ? 1 : -1);
                if (next_lvl >= int'(fade_peak))
                begin
                    next_lvl = int'(fade_peak);
                    fade_up  = 1'b0;
                end
                if (next_lvl <= 0)
                begin
                    next_lvl = 0;
                    fade_up  = 1'b1;
                end
                fade_lvl  = next_lvl[FADE_W-1:0];
                led_a_reg = fade_lvl;
                led_b_reg = fade_lvl;
                ind_reg   = 1'b0;
            end
            fade_cnt++;
            if (fade_cnt >= int'(fade_per))
                fade_cnt = 0;
        end

        f.led_a = led_a_reg;
        f.led_b = led_b_reg;
        f.ind   = ind_reg;
        f.mode  = cur_mode;
        return f;
    endfunction

    task automatic send_tick(input logic mlev, input logic rlev);
        in_valid           <= 1'b1;
        mode_button_level  <= mlev;
        reset_button_level <= rlev;
        do
            @(posedge clk);
        while (in_stall);
        led_frames_due.push_back(step_led_controller(mlev, rlev));
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (led_frames_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_DEBOUNCE:  deb_ticks = val[DEB_W-1:0];
            CFG_BLINK:     blink_ivl = val[BLINK_W-1:0];
            CFG_FADE_PEAK: fade_peak = val[FADE_W-1:0];
            default:       fade_per  = val[FADE_W-1:0];
        endcase
    endtask

    task automatic load_settings(input int deb, input int blink, input int pk, input int per);
        wait_for_results();
        write_reg(CFG_DEBOUNCE, CFG_DATA_W'(deb));
        write_reg(CFG_BLINK, CFG_DATA_W'(blink));
        write_reg(CFG_FADE_PEAK, CFG_DATA_W'(pk));
        write_reg(CFG_FADE_PERIOD, CFG_DATA_W'(per));
        cfg_valid <= 1'b0;
    endtask

    function automatic int pick_run();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(1, int'(deb_ticks) + 1);
        return int'(deb_ticks) + $urandom_range(2, 6);
    endfunction

    task automatic press_buttons(input int n_items);
        int   left_m;
        int   left_r;
        logic lm;
        logic lr;
        left_m = 0;
        left_r = 0;
        lm     = btn_prev[MODE_IDX];
        lr     = btn_prev[RESET_IDX];
        for (int i = 0; i < n_items; i++)
        begin
            if (left_m == 0)
            begin
                if ($urandom_range(0, 7) != 0)
                    lm = ~lm;
                left_m = pick_run();
            end
            if (left_r == 0)
            begin
                lr     = (!lr || $urandom_range(0, 4) != 0) ? 1'b1 : 1'b0;
                left_r = pick_run();
            end
            left_m--;
            left_r--;
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            send_tick(lm, lr);
        end
    endtask

    task automatic test_power_on_defaults();
        press_buttons(100);
    endtask

    task automatic test_directed_sequences();
        logic [1:0] seq[$];
        seq = '{2'b11,
                2'b01, 2'b01, 2'b11, 2'b11, 2'b01, 2'b01, 2'b11, 2'b11,
                2'b01, 2'b01, 2'b11, 2'b11, 2'b01, 2'b01, 2'b11, 2'b11,
                2'b00, 2'b00, 2'b11, 2'b10, 2'b11, 2'b01, 2'b01,
                2'b10, 2'b10, 2'b11};
        load_settings(0, 1, 1, 1);
        foreach (seq[i])
            send_tick(seq[i][1], seq[i][0]);
    endtask

    task automatic test_fast_cycling();
        load_settings(0, 1, 255, 1);
        press_buttons(100);
    endtask

    task automatic test_mid_settings();
        load_settings(2, 5, 7, 2);
        press_buttons(60);
        wait_for_results();
        press_buttons(60);
    endtask

    task automatic test_slow_extremes();
        load_settings(1023, 65535, 255, 255);
        press_buttons(300);
    endtask

    task automatic test_random_settings();
        for (int p = 0; p < 4; p++)
        begin
            load_settings($urandom_range(0, 4), $urandom_range(1, 8),
                          $urandom_range(1, 12), $urandom_range(1, 3));
            press_buttons(40);
        end
    endtask

    task automatic test_quiet_finish();
        load_settings(3, 3, 4, 1);
        quiet = 1'b1;
        press_buttons(150);
    endtask

    initial
    begin : stall_gen
        wait (rst_n);
        forever
        begin
            repeat ($urandom_range(1, 40)) @(posedge clk);
            if (!quiet)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        led_frame_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (led_frames_due.size() == 0)
                flag_error("result with nothing pending, led_a_level", -1, led_a_level);
            else
            begin
                want = led_frames_due.pop_front();
                if (led_a_level !== want.led_a)
                    flag_error("led_a_level", want.led_a, led_a_level);
                if (led_b_level !== want.led_b)
                    flag_error("led_b_level", want.led_b, led_b_level);
                if (indicator_on !== want.ind)
                    flag_error("indicator_on", want.ind, indicator_on);
                if (current_mode !== want.mode)
                    flag_error("current_mode", want.mode, current_mode);
                if (mode_entered !== want.entered)
                    flag_error("mode_entered", want.entered, mode_entered);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[debounced_led_mode_controller_top] ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        reset_led_model();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_power_on_defaults();
        test_directed_sequences();
        test_fast_cycling();
        test_mid_settings();
        test_slow_extremes();
        test_random_settings();
        test_quiet_finish();
        wait_for_results();
        if (led_frames_due.size() != 0)
            flag_error("results left pending", 0, led_frames_due.size());
        if (mismatches == 0)
            $display("[debounced_led_mode_controller_top] OK");
        else
            $display("[debounced_led_mode_controller_top] ERROR");
        $finish;
    end

endmodule

// File: debounced_led_mode_controller_top.f
rtl/dlmc_pkg.sv
rtl/debounced_led_mode_controller_top.sv
test/tb.sv
